/* hdl/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the barometric compensation pipe.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] T_OFFSET   = 32'd4000;
    localparam logic [31:0] P_COEF1    = 32'd3038;
    localparam logic [31:0] P_COEF2    = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] P_COEF3    = 32'd3791;
    localparam logic [31:0] P_SCALE    = 32'd50000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;

    // Side data carried through the temperature divider
    typedef struct packed {
        logic [31:0] x1;
        logic [23:0] up;
        logic        neg;
        logic        fault;
    } bsc_tside_t;

    // Side data carried through the pressure divider
    typedef struct packed {
        logic [15:0] temp;
        logic        fault;
        logic        dbl;
    } bsc_pside_t;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* hdl/bsc_udiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_udiv #(
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   dividend,
    input  logic [31:0]   divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [31:0]   quotient,
    output logic [SW-1:0] side_out
);

    localparam int N = 32;

    logic [N-1:0]  v_reg;
    logic [31:0]   n_reg [N];
    logic [31:0]   r_reg [N];
    logic [31:0]   d_reg [N];
    logic [SW-1:0] s_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic          v_prev;
            logic [31:0]   n_prev;
            logic [31:0]   r_prev;
            logic [31:0]   d_prev;
            logic [SW-1:0] s_prev;
            logic [32:0]   shifted;
            logic [32:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign v_prev = in_valid;
                assign n_prev = dividend;
                assign r_prev = '0;
                assign d_prev = divisor;
                assign s_prev = side_in;
            end
            else
            begin : g_next
                assign v_prev = v_reg[k-1];
                assign n_prev = n_reg[k-1];
                assign r_prev = r_reg[k-1];
                assign d_prev = d_reg[k-1];
                assign s_prev = s_reg[k-1];
            end

            assign shifted = {r_prev, n_prev[31]};
            assign diff    = shifted - {1'b0, d_prev};
            assign ge      = !diff[32];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k] <= {n_prev[30:0], ge};
                    r_reg[k] <= ge ? diff[31:0] : shifted[31:0];
                    d_reg[k] <= d_prev;
                    s_reg[k] <= s_prev;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign quotient  = n_reg[N-1];
    assign side_out  = s_reg[N-1];

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("divider valid bits moved while stalled");

endmodule

/* hdl/barometric_sensor_compensation_unit.sv */
`timescale 1ns / 1ps
// Path: each accepted request passes through the two 32-stage divider
// pipelines (temperature divisor and pressure divisor) on its way to the result.
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Reset: all valid bits clear, coefficients reset to 0, oversampling to 1.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_unit
// Integer temperature and pressure compensation for a digital barometer.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] raw_temperature,
    input  logic [23:0] raw_pressure,
    output logic        result_valid,
    input  logic        result_ready,
    output logic signed [15:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic        divide_fault
);

    import bsc_pkg::*;

    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= '0;
            ac3_ac4_reg <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= 2'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AC1_AC2: ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4: ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                REG_B1_B2:   b1_b2_reg   <= cfg_data;
                REG_MC_MD:   mc_md_reg   <= cfg_data;
                REG_OSS:     oss_reg     <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sext16(ac1_ac2_reg[31:16]);
    assign ac2 = sext16(ac1_ac2_reg[15:0]);
    assign ac3 = sext16(ac3_ac4_reg[31:16]);
    assign ac4 = {16'd0, ac3_ac4_reg[15:0]};
    assign ac5 = {16'd0, ac5_ac6_reg[31:16]};
    assign ac6 = {16'd0, ac5_ac6_reg[15:0]};
    assign b1  = sext16(b1_b2_reg[31:16]);
    assign b2  = sext16(b1_b2_reg[15:0]);
    assign mc  = sext16(mc_md_reg[31:16]);
    assign md  = sext16(mc_md_reg[15:0]);

    logic adv;
    assign adv          = !result_valid || result_ready;
    assign sample_ready = adv;

    // valid bits of the stages outside the dividers
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg, s12_v_reg, out_v_reg;
    logic d1_v, d2_v;

    // ---------------- temperature front end ----------------
    logic [31:0] s1_d_reg;
    logic [23:0] s1_up_reg;
    logic [31:0] s2_m_reg;
    logic [23:0] s2_up_reg;
    logic [31:0] s3_x1_reg, s3_den_reg;
    logic [23:0] s3_up_reg;
    logic [31:0] s4_a_reg, s4_b_reg;
    bsc_tside_t  s4_side_reg;

    logic [31:0] up_next, x1_s3, num_s4;
    logic [3:0]  up_shift;
    assign up_shift = 4'd8 - {2'b00, oss_reg};
    assign up_next  = {8'd0, raw_pressure} >> up_shift;
    assign x1_s3    = asr(s2_m_reg, 5'd15);
    assign num_s4   = mc << 11;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_d_reg  <= sext16(raw_temperature) - ac6;
            s1_up_reg <= up_next[23:0];
            s2_m_reg  <= s1_d_reg * ac5;
            s2_up_reg <= s1_up_reg;
            s3_x1_reg <= x1_s3;
            s3_den_reg <= x1_s3 + md;
            s3_up_reg <= s2_up_reg;
            s4_a_reg  <= num_s4[31] ? 32'd0 - num_s4 : num_s4;
            s4_b_reg  <= s3_den_reg[31] ? 32'd0 - s3_den_reg : s3_den_reg;
            s4_side_reg.x1    <= s3_x1_reg;
            s4_side_reg.up    <= s3_up_reg;
            s4_side_reg.neg   <= num_s4[31] ^ s3_den_reg[31];
            s4_side_reg.fault <= (s3_den_reg == 32'd0);
        end
    end

    logic [31:0] d1_q;
    bsc_tside_t  d1_side;

    bsc_udiv #(.SW($bits(bsc_tside_t))) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_v_reg),
        .dividend  (s4_a_reg),
        .divisor   (s4_b_reg),
        .side_in   (s4_side_reg),
        .out_valid (d1_v),
        .quotient  (d1_q),
        .side_out  (d1_side)
    );

    // ---------------- pressure middle section ----------------
    logic [31:0] q1_s5, x2_s5, b5_s5, t_s5;
    logic [15:0] tsat_s5;
    assign q1_s5 = d1_side.neg ? 32'd0 - d1_q : d1_q;
    assign x2_s5 = d1_side.fault ? 32'd0 : q1_s5;
    assign b5_s5 = d1_side.x1 + x2_s5;
    assign t_s5  = asr(b5_s5 + 32'd8, 5'd4);

    always_comb
    begin
        if (!t_s5[31] && (t_s5[30:15] != 16'h0000))
        begin
            tsat_s5 = 16'h7FFF;
        end
        else if (t_s5[31] && (t_s5[30:15] != 16'hFFFF))
        begin
            tsat_s5 = 16'h8000;
        end
        else
        begin
            tsat_s5 = t_s5[15:0];
        end
    end

    logic [31:0] s5_b6_reg;
    logic [15:0] s5_t_reg, s6_t_reg, s7_t_reg, s8_t_reg, s9_t_reg;
    logic [23:0] s5_up_reg, s6_up_reg, s7_up_reg, s8_up_reg;
    logic        s5_f_reg, s6_f_reg, s7_f_reg, s8_f_reg, s9_f_reg;
    logic [31:0] s6_sq_reg, s6_ac2b6_reg, s6_ac3b6_reg;
    logic [31:0] s7_b2sq_reg, s7_b1sq_reg, s7_ac2b6_reg, s7_ac3b6_reg;
    logic [31:0] s8_b3_reg, s8_x3p_reg;
    logic [31:0] s9_b4p_reg, s9_b7_reg;

    logic [31:0] b6sq_s7, x3_s8, a_s8, b3_s8, x3p_s8, b7_s9;
    assign b6sq_s7 = asr(s6_sq_reg, 5'd12);
    assign x3_s8   = asr(s7_b2sq_reg, 5'd11) + asr(s7_ac2b6_reg, 5'd11);
    assign a_s8    = (((ac1 << 2) + x3_s8) << oss_reg) + 32'd2;
    // signed divide by four, truncating toward zero
    assign b3_s8   = asr(a_s8 + (a_s8[31] ? 32'd3 : 32'd0), 5'd2);
    assign x3p_s8  = asr(asr(s7_ac3b6_reg, 5'd13) + asr(s7_b1sq_reg, 5'd16) + 32'd2, 5'd2);
    assign b7_s9   = {8'd0, s8_up_reg} - s8_b3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_b6_reg    <= b5_s5 - T_OFFSET;
            s5_t_reg     <= tsat_s5;
            s5_up_reg    <= d1_side.up;
            s5_f_reg     <= d1_side.fault;

            s6_sq_reg    <= s5_b6_reg * s5_b6_reg;
            s6_ac2b6_reg <= ac2 * s5_b6_reg;
            s6_ac3b6_reg <= ac3 * s5_b6_reg;
            s6_t_reg     <= s5_t_reg;
            s6_up_reg    <= s5_up_reg;
            s6_f_reg     <= s5_f_reg;

            s7_b2sq_reg  <= b2 * b6sq_s7;
            s7_b1sq_reg  <= b1 * b6sq_s7;
            s7_ac2b6_reg <= s6_ac2b6_reg;
            s7_ac3b6_reg <= s6_ac3b6_reg;
            s7_t_reg     <= s6_t_reg;
            s7_up_reg    <= s6_up_reg;
            s7_f_reg     <= s6_f_reg;

            s8_b3_reg    <= b3_s8;
            s8_x3p_reg   <= x3p_s8;
            s8_t_reg     <= s7_t_reg;
            s8_up_reg    <= s7_up_reg;
            s8_f_reg     <= s7_f_reg;

            s9_b4p_reg   <= ac4 * (s8_x3p_reg + B4_OFFSET);
            s9_b7_reg    <= b7_s9 * (P_SCALE >> oss_reg);
            s9_t_reg     <= s8_t_reg;
            s9_f_reg     <= s8_f_reg;
        end
    end

    // ---------------- pressure division ----------------
    logic [31:0] s10_n_reg, s10_d_reg;
    bsc_pside_t  s10_side_reg;
    logic [31:0] b4_s10;
    assign b4_s10 = s9_b4p_reg >> 15;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_n_reg          <= s9_b7_reg[31] ? s9_b7_reg : s9_b7_reg << 1;
            s10_d_reg          <= b4_s10;
            s10_side_reg.temp  <= s9_t_reg;
            s10_side_reg.fault <= s9_f_reg || (b4_s10 == 32'd0);
            s10_side_reg.dbl   <= s9_b7_reg[31];
        end
    end

    logic [31:0] d2_q;
    bsc_pside_t  d2_side;

    bsc_udiv #(.SW($bits(bsc_pside_t))) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s10_v_reg),
        .dividend  (s10_n_reg),
        .divisor   (s10_d_reg),
        .side_in   (s10_side_reg),
        .out_valid (d2_v),
        .quotient  (d2_q),
        .side_out  (d2_side)
    );

    // ---------------- pressure correction ----------------
    logic [31:0] p_s11, p8_s11;
    assign p_s11  = d2_side.dbl ? d2_q << 1 : d2_q;
    assign p8_s11 = asr(p_s11, 5'd8);

    logic [31:0] s11_p_reg, s11_sq_reg, s11_x2m_reg;
    logic [31:0] s12_p_reg, s12_x1m_reg, s12_x2m_reg;
    logic [15:0] s11_t_reg, s12_t_reg;
    logic        s11_f_reg, s12_f_reg;

    logic [31:0] corr_s13;
    assign corr_s13 = asr(asr(s12_x1m_reg, 5'd16) + asr(s12_x2m_reg, 5'd16) + P_COEF3,
                          5'd4);

    logic [15:0] temp_out_reg;
    logic [31:0] press_out_reg;
    logic        fault_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_p_reg     <= p_s11;
            s11_sq_reg    <= p8_s11 * p8_s11;
            s11_x2m_reg   <= P_COEF2 * p_s11;
            s11_t_reg     <= d2_side.temp;
            s11_f_reg     <= d2_side.fault;

            s12_p_reg     <= s11_p_reg;
            s12_x1m_reg   <= s11_sq_reg * P_COEF1;
            s12_x2m_reg   <= s11_x2m_reg;
            s12_t_reg     <= s11_t_reg;
            s12_f_reg     <= s11_f_reg;

            temp_out_reg  <= s12_t_reg;
            press_out_reg <= s12_f_reg ? 32'd0 : s12_p_reg + corr_s13;
            fault_out_reg <= s12_f_reg;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= sample_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= d1_v;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= d2_v;
            s12_v_reg <= s11_v_reg;
            out_v_reg <= s12_v_reg;
        end
    end

    assign result_valid       = out_v_reg;
    assign temperature_tenths = $signed(temp_out_reg);
    assign pressure_pa        = $signed(press_out_reg);
    assign divide_fault       = fault_out_reg;

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && divide_fault |-> pressure_pa == 32'sd0)
        else $error("fault result carries nonzero pressure");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready == (!result_valid || result_ready))
        else $error("input ready does not follow output stall");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s12_v_reg) && $stable(s5_v_reg) && $stable(s1_v_reg))
        else $error("pipeline moved while stalled");

endmodule
